// ===== sv/assert_macros.svh =====
// assertion macros for the crossfader
// used by the top level, expects clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ECF_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition implies expectation on the following edge
`define ECF_ASSERT_NEXT(name, cond, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (post)) \
		else $error(msg);

`endif

// ===== sv/ecf_pkg.sv =====
// shared types and constants for the equal-power crossfader
// no dependencies
package ecf_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int TABLE_BITS  = 10;

	localparam int TBL_N     = 1 << TABLE_BITS;
	localparam int ADDR_W    = TABLE_BITS + 1;
	localparam int Q_W       = 24;
	localparam int FRAC_W    = 23;
	localparam int GAIN_W    = FRAC_W + 1;
	localparam int IDX_SHIFT = FRAC_W - TABLE_BITS;
	localparam int SAT_W     = SAMPLE_BITS + 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [Q_W-1:0] ONE_Q23    = Q_W'(1) << FRAC_W;
	localparam logic [Q_W-1:0] STEP_RESET = Q_W'(17476);

	localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MONO_STEP = CFG_IDX_W'(1);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] main_left;
		logic signed [SAMPLE_BITS-1:0] main_right;
		logic signed [SAMPLE_BITS-1:0] ref_left;
		logic signed [SAMPLE_BITS-1:0] ref_right;
		logic                          select_b;
		logic                          mono_on;
	} frame_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_left;
		logic signed [SAMPLE_BITS-1:0] out_right;
	} result_t;

	typedef struct packed {
		logic           settled;
		logic           sel_b;
		logic [Q_W-1:0] mono_amt;
	} mix_ctl_t;

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [SAT_W-1:0] v
	);
		logic hi_same;
		logic hi_ones;
		hi_same = ~|v[SAT_W-1:SAMPLE_BITS-1];
		hi_ones = &v[SAT_W-1:SAMPLE_BITS-1];
		if (hi_same || hi_ones) begin
			return v[SAMPLE_BITS-1:0];
		end else if (v[SAT_W-1]) begin
			return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	endfunction

endpackage

// ===== sv/ecf_rom.sv =====
// quarter-sine gain rom, two registered read ports (sin and cos)
// depends on ecf_pkg; table contents computed at elaboration
module ecf_rom import ecf_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [ADDR_W-1:0] sin_addr,
	input  logic [ADDR_W-1:0] cos_addr,
	output logic [GAIN_W-1:0] gain_sin_s1,
	output logic [GAIN_W-1:0] gain_cos_s1
);

	typedef logic [GAIN_W-1:0] gain_tab_t [0:TBL_N];

	localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// term divisor (2k)(2k+1) of the taylor series
	function automatic logic [63:0] div_term(input logic [63:0] v, input int k);
		logic [63:0] q;
		unique case (k)
			1:       q = v / 64'd6;
			2:       q = v / 64'd20;
			3:       q = v / 64'd42;
			4:       q = v / 64'd72;
			5:       q = v / 64'd110;
			6:       q = v / 64'd156;
			7:       q = v / 64'd210;
			8:       q = v / 64'd272;
			9:       q = v / 64'd342;
			10:      q = v / 64'd420;
			11:      q = v / 64'd506;
			12:      q = v / 64'd600;
			13:      q = v / 64'd702;
			14:      q = v / 64'd812;
			15:      q = v / 64'd930;
			default: q = v;
		endcase
		return q;
	endfunction

	function automatic gain_tab_t build_sine_tab();
		gain_tab_t   tab;
		logic [63:0] base;
		logic [63:0] rem;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] rnd;
		base = HALF_PI_Q60 >> TABLE_BITS;
		rem  = HALF_PI_Q60 & 64'(TBL_N - 1);
		for (int i = 0; i <= TBL_N; i++) begin
			x    = base * 64'(i) + ((rem * 64'(i)) >> TABLE_BITS);
			x2   = mul_q60(x, x);
			term = x;
			sum  = x;
			for (int k = 1; k < 16; k++) begin
				term = div_term(mul_q60(term, x2), k);
				if ((k & 1) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			rnd    = (sum + (64'd1 << 36)) >> 37;
			tab[i] = rnd[GAIN_W-1:0];
		end
		return tab;
	endfunction

	localparam gain_tab_t SINE_TAB = build_sine_tab();

	always_ff @(posedge clk) begin
		if (en) begin
			gain_sin_s1 <= SINE_TAB[sin_addr];
			gain_cos_s1 <= SINE_TAB[cos_addr];
		end
	end

endmodule

// ===== sv/ecf_ramp.sv =====
// fade position and mono amount ramps, rom addressing, stage 1 control
// depends on ecf_pkg
module ecf_ramp import ecf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              adv,
	input  logic              select_b,
	input  logic              mono_on,
	input  logic [Q_W-1:0]    fade_step,
	input  logic [Q_W-1:0]    mono_step,
	output logic [ADDR_W-1:0] sin_addr,
	output logic [ADDR_W-1:0] cos_addr,
	output mix_ctl_t          ctl_s1
);

	logic [Q_W-1:0] fade_pos_q;
	logic [Q_W-1:0] mono_q;
	logic [Q_W-1:0] fade_tgt;
	logic [Q_W-1:0] mono_tgt;
	logic [Q_W-1:0] fade_next;
	logic [Q_W-1:0] mono_next;
	logic           settled;

	function automatic logic [Q_W-1:0] ramp(
		input logic [Q_W-1:0] cur,
		input logic [Q_W-1:0] tgt,
		input logic [Q_W-1:0] step
	);
		logic [Q_W-1:0] r;
		if (cur < tgt) begin
			r = (step >= tgt - cur) ? tgt : cur + step;
		end else if (cur > tgt) begin
			r = (step >= cur - tgt) ? tgt : cur - step;
		end else begin
			r = cur;
		end
		return r;
	endfunction

	assign fade_tgt  = select_b ? ONE_Q23 : '0;
	assign mono_tgt  = mono_on ? ONE_Q23 : '0;
	assign settled   = (fade_pos_q == fade_tgt);
	assign fade_next = ramp(fade_pos_q, fade_tgt, fade_step);
	assign mono_next = ramp(mono_q, mono_tgt, mono_step);

	assign sin_addr = fade_next[FRAC_W:IDX_SHIFT];
	assign cos_addr = ADDR_W'(TBL_N) - fade_next[FRAC_W:IDX_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_pos_q <= '0;
			mono_q     <= '0;
		end else if (accept) begin
			fade_pos_q <= fade_next;
			mono_q     <= mono_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1.settled  <= settled;
			ctl_s1.sel_b    <= select_b;
			ctl_s1.mono_amt <= mono_next;
		end
	end

endmodule

// ===== sv/ecf_lane.sv =====
// one channel of the crossfade: gain products, round, saturate
// depends on ecf_pkg; gains come from ecf_rom
module ecf_lane import ecf_pkg::*; (
	input  logic                          clk,
	input  logic                          adv,
	input  mix_ctl_t                      ctl_s1,
	input  logic signed [SAMPLE_BITS-1:0] main_s1,
	input  logic signed [SAMPLE_BITS-1:0] ref_s1,
	input  logic        [GAIN_W-1:0]      gain_sin_s1,
	input  logic        [GAIN_W-1:0]      gain_cos_s1,
	output logic signed [SAMPLE_BITS-1:0] mix_s3
);

	localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
	localparam int SUM_W  = PROD_W + 1;

	logic signed [PROD_W-1:0]      prod_main_s2;
	logic signed [PROD_W-1:0]      prod_ref_s2;
	logic signed [SAMPLE_BITS-1:0] main_s2;
	logic signed [SAMPLE_BITS-1:0] ref_s2;
	logic                          settled_s2;
	logic                          sel_b_s2;
	logic signed [SUM_W-1:0]       sum;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_main_s2 <= PROD_W'(main_s1 * $signed({1'b0, gain_cos_s1}));
			prod_ref_s2  <= PROD_W'(ref_s1 * $signed({1'b0, gain_sin_s1}));
			main_s2      <= main_s1;
			ref_s2       <= ref_s1;
			settled_s2   <= ctl_s1.settled;
			sel_b_s2     <= ctl_s1.sel_b;
		end
	end

	assign sum = SUM_W'(prod_main_s2) + SUM_W'(prod_ref_s2)
		+ (SUM_W'(1) <<< (FRAC_W - 1));

	always_ff @(posedge clk) begin
		if (adv) begin
			if (settled_s2) begin
				mix_s3 <= sel_b_s2 ? ref_s2 : main_s2;
			end else begin
				mix_s3 <= sat_sample(sum[SUM_W-1:FRAC_W]);
			end
		end
	end

endmodule

// ===== sv/ecf_merge.sv =====
// merging stage: mono blend of both lanes toward the mid signal
// depends on ecf_pkg; takes the lane outputs of ecf_lane
module ecf_merge import ecf_pkg::*; (
	input  logic                          clk,
	input  logic                          adv,
	input  logic signed [SAMPLE_BITS-1:0] left_s3,
	input  logic signed [SAMPLE_BITS-1:0] right_s3,
	input  logic        [Q_W-1:0]         mono_s3,
	output result_t                       res_s5
);

	localparam int DIFF_W     = SAMPLE_BITS + 1;
	localparam int MPROD_W    = DIFF_W + Q_W + 1;
	localparam int NSUM_W     = MPROD_W + 1;
	localparam int MONO_SHIFT = FRAC_W + 1;

	logic signed [DIFF_W-1:0]      diff;
	logic signed [MPROD_W-1:0]     prod_l_s4;
	logic signed [MPROD_W-1:0]     prod_r_s4;
	logic signed [SAMPLE_BITS-1:0] left_s4;
	logic signed [SAMPLE_BITS-1:0] right_s4;
	logic signed [NSUM_W-1:0]      sum_l;
	logic signed [NSUM_W-1:0]      sum_r;
	logic signed [NSUM_W-1:0]      half;

	assign diff = DIFF_W'(right_s3) - DIFF_W'(left_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_l_s4 <= MPROD_W'(diff * $signed({1'b0, mono_s3}));
			prod_r_s4 <= MPROD_W'(-diff * $signed({1'b0, mono_s3}));
			left_s4   <= left_s3;
			right_s4  <= right_s3;
		end
	end

	assign half  = NSUM_W'(1) <<< (MONO_SHIFT - 1);
	assign sum_l = (NSUM_W'(left_s4) <<< MONO_SHIFT) + NSUM_W'(prod_l_s4) + half;
	assign sum_r = (NSUM_W'(right_s4) <<< MONO_SHIFT) + NSUM_W'(prod_r_s4) + half;

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s5.out_left  <= sat_sample(sum_l[NSUM_W-1:MONO_SHIFT]);
			res_s5.out_right <= sat_sample(sum_r[NSUM_W-1:MONO_SHIFT]);
		end
	end

endmodule

// ===== sv/equal_power_ab_crossfader_top.sv =====
// top level of the equal-power a/b crossfader with mono blend
// depends on ecf_pkg, ecf_ramp, ecf_rom, ecf_lane, ecf_merge, assert_macros.svh
//
// usage:
//   frame channel (frame_valid, frame, frame_stall) carries one stereo frame:
//   main and reference pairs plus the select_b and mono_on bits. a transfer
//   happens on a clock edge with valid high and stall low.
//   result channel (result_valid, result, result_stall) returns one frame
//   per input frame, in order.
//   config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
//   fade_step (index 0) and mono_step (index 1); cfg_ready is always high.
//   write config only while no frame is in flight.
// timing:
//   one frame per cycle sustained while result_stall is low. the ramp
//   registers step and the two-port gain rom is read at the transfer edge;
//   then follow the gain multiply, the round and saturate, the mono
//   multiply and the output register, each a registered stage.
// reset and stall:
//   arst_n clears fade position and mono amount to zero (fully on a, stereo),
//   both steps to 17476, and empties the pipeline. while result_stall holds a
//   waiting result the whole pipeline freezes and frame_stall is raised.
`include "assert_macros.svh"

module equal_power_ab_crossfader_top import ecf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 frame_valid,
	input  frame_t               frame,
	output logic                 frame_stall,
	output logic                 result_valid,
	output result_t              result,
	input  logic                 result_stall,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [Q_W-1:0]       cfg_data
);

	logic              adv;
	logic              accept;
	logic [Q_W-1:0]    fade_step_q;
	logic [Q_W-1:0]    mono_step_q;
	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic              valid_s4;
	logic              valid_s5;
	logic [ADDR_W-1:0] sin_addr;
	logic [ADDR_W-1:0] cos_addr;
	logic [GAIN_W-1:0] gain_sin_s1;
	logic [GAIN_W-1:0] gain_cos_s1;
	mix_ctl_t          ctl_s1;
	frame_t            frame_s1;
	logic [Q_W-1:0]    mono_s2;
	logic [Q_W-1:0]    mono_s3;
	logic signed [SAMPLE_BITS-1:0] left_s3;
	logic signed [SAMPLE_BITS-1:0] right_s3;

	assign adv          = !(valid_s5 && result_stall);
	assign accept       = frame_valid && adv;
	assign frame_stall  = !adv;
	assign result_valid = valid_s5;
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_step_q <= STEP_RESET;
			mono_step_q <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FADE_STEP: fade_step_q <= cfg_data;
				REG_MONO_STEP: mono_step_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= frame_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frame_s1 <= frame;
			mono_s2  <= ctl_s1.mono_amt;
			mono_s3  <= mono_s2;
		end
	end

	ecf_ramp u_ramp (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.adv       (adv),
		.select_b  (frame.select_b),
		.mono_on   (frame.mono_on),
		.fade_step (fade_step_q),
		.mono_step (mono_step_q),
		.sin_addr  (sin_addr),
		.cos_addr  (cos_addr),
		.ctl_s1    (ctl_s1)
	);

	ecf_rom u_rom (
		.clk         (clk),
		.en          (adv),
		.sin_addr    (sin_addr),
		.cos_addr    (cos_addr),
		.gain_sin_s1 (gain_sin_s1),
		.gain_cos_s1 (gain_cos_s1)
	);

	ecf_lane u_lane_left (
		.clk         (clk),
		.adv         (adv),
		.ctl_s1      (ctl_s1),
		.main_s1     (frame_s1.main_left),
		.ref_s1      (frame_s1.ref_left),
		.gain_sin_s1 (gain_sin_s1),
		.gain_cos_s1 (gain_cos_s1),
		.mix_s3      (left_s3)
	);

	ecf_lane u_lane_right (
		.clk         (clk),
		.adv         (adv),
		.ctl_s1      (ctl_s1),
		.main_s1     (frame_s1.main_right),
		.ref_s1      (frame_s1.ref_right),
		.gain_sin_s1 (gain_sin_s1),
		.gain_cos_s1 (gain_cos_s1),
		.mix_s3      (right_s3)
	);

	ecf_merge u_merge (
		.clk      (clk),
		.adv      (adv),
		.left_s3  (left_s3),
		.right_s3 (right_s3),
		.mono_s3  (mono_s3),
		.res_s5   (result)
	);

	`ECF_ASSERT_NEXT(a_shift_out, adv, valid_s5 == $past(valid_s4), "result valid lost")
	`ECF_ASSERT_NEXT(a_freeze, !adv, $stable(valid_s1) && $stable(valid_s3), "moved while frozen")
	`ECF_ASSERT(a_mono_range, !valid_s1 || (ctl_s1.mono_amt <= ONE_Q23), "mono above unity")
	`ECF_ASSERT_NEXT(a_take, accept, valid_s1, "accepted frame not in stage one")

endmodule

// ===== tb/sv/tb_equal_power_ab_crossfader_top.sv =====
`timescale 1ns / 100ps
// self-checking bench for the equal-power a/b crossfader: random and directed frames,
// step registers swept between phases, outputs checked against a cycle-free predictor
// depends on ecf_pkg and equal_power_ab_crossfader_top
module tb_equal_power_ab_crossfader_top;
	import ecf_pkg::*;

	localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

	class mix_scoreboard;
		result_t pending_mix[$];
		int unsigned errors;
		logic [Q_W-1:0] fade_step, mono_step, fade_pos, mono_amt;
		longint sine_q23[TBL_N+1];

		function new();
			longint unsigned base, rem, x, x2, term, sum;
			base = HALF_PI_Q60 >> TABLE_BITS;
			rem = HALF_PI_Q60 & (TBL_N - 1);
			for (int i = 0; i <= TBL_N; i++) begin
				x = base * i + ((rem * i) >> TABLE_BITS);
				x2 = q60_mul(x, x);
				term = x;
				sum = x;
				for (int k = 1; k < 16; k++) begin
					term = q60_mul(term, x2) / 64'(2 * k * (2 * k + 1));
					if (k & 1) begin
						sum -= term;
					end else begin
						sum += term;
					end
				end
				sine_q23[i] = longint'((sum + (64'd1 << 36)) >> 37);
			end
			fade_step = STEP_RESET;
			mono_step = STEP_RESET;
			fade_pos = '0;
			mono_amt = '0;
			errors = 0;
		endfunction

		function longint unsigned q60_mul(longint unsigned a, longint unsigned b);
			logic [127:0] p;
			p = {64'd0, a} * {64'd0, b};
			return p[123:60];
		endfunction

		function logic [Q_W-1:0] ramp_to(logic [Q_W-1:0] cur, logic [Q_W-1:0] tgt,
				logic [Q_W-1:0] step);
			if (cur < tgt) return (step >= tgt - cur) ? tgt : cur + step;
			if (cur > tgt) return (step >= cur - tgt) ? tgt : cur - step;
			return cur;
		endfunction

		function longint shift_round(longint v, int sh);
			return (v + (longint'(1) <<< (sh - 1))) >>> sh;
		endfunction

		function longint clip(longint v);
			longint top;
			top = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
			if (v > top) return top;
			if (v < -top - 1) return -top - 1;
			return v;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] data);
			case (idx)
				REG_FADE_STEP: fade_step = data;
				REG_MONO_STEP: mono_step = data;
				default: ;
			endcase
		endfunction

		function void note_frame(frame_t f);
			longint ml, mr, rl, rr, l, r, gs, gc, a, nl, nr;
			logic [Q_W-1:0] ftgt, mtgt;
			int unsigned idx;
			result_t res;
			ml = f.main_left;
			mr = f.main_right;
			rl = f.ref_left;
			rr = f.ref_right;
			ftgt = f.select_b ? ONE_Q23 : '0;
			mtgt = f.mono_on ? ONE_Q23 : '0;
			if (fade_pos == ftgt) begin
				l = f.select_b ? rl : ml;
				r = f.select_b ? rr : mr;
			end else begin
				fade_pos = ramp_to(fade_pos, ftgt, fade_step);
				idx = fade_pos >> IDX_SHIFT;
				gs = sine_q23[idx];
				gc = sine_q23[TBL_N - idx];
				l = clip(shift_round(ml * gc + rl * gs, FRAC_W));
				r = clip(shift_round(mr * gc + rr * gs, FRAC_W));
			end
			mono_amt = ramp_to(mono_amt, mtgt, mono_step);
			if (mono_amt != 0) begin
				a = longint'(mono_amt);
				nl = l * (longint'(1) <<< 24) + (r - l) * a;
				nr = r * (longint'(1) <<< 24) + (l - r) * a;
				l = clip(shift_round(nl, 24));
				r = clip(shift_round(nr, 24));
			end
			res.out_left = SAMPLE_BITS'(l);
			res.out_right = SAMPLE_BITS'(r);
			pending_mix.push_back(res);
		endfunction

		function void check_mix(result_t got);
			result_t want;
			if (pending_mix.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual L %0d R %0d",
					$time, got.out_left, got.out_right);
				return;
			end
			want = pending_mix.pop_front();
			if (got.out_left !== want.out_left) begin
				errors++;
				$display("%0t: out_left expected %0d actual %0d", $time,
					want.out_left, got.out_left);
			end
			if (got.out_right !== want.out_right) begin
				errors++;
				$display("%0t: out_right expected %0d actual %0d", $time,
					want.out_right, got.out_right);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic frame_valid = 1'b0;
	frame_t frame = '0;
	logic frame_stall;
	logic result_valid;
	result_t result;
	logic result_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FADE_STEP;
	logic [Q_W-1:0] cfg_data = '0;

	mix_scoreboard sb;
	logic cur_sel = 1'b0;
	logic cur_mono = 1'b0;
	int unsigned tx_calm = 0;

	equal_power_ab_crossfader_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame(frame),
		.frame_stall(frame_stall),
		.result_valid(result_valid),
		.result(result),
		.result_stall(result_stall),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 11))
			0: return SMAX;
			1: return SMIN;
			2: return '0;
			3: return '1;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	task automatic send_frame(input frame_t f);
		int unsigned gap;
		if (tx_calm > 0) begin
			tx_calm--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 4);
			if ($urandom_range(0, 24) == 0) tx_calm = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			frame_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_valid <= 1'b1;
		frame <= f;
		do @(posedge clk); while (frame_stall);
		sb.note_frame(f);
	endtask

	task automatic send_fields(input logic signed [SAMPLE_BITS-1:0] ml, mr, rl, rr,
			input logic sel, mono);
		frame_t f;
		f.main_left = ml;
		f.main_right = mr;
		f.ref_left = rl;
		f.ref_right = rr;
		f.select_b = sel;
		f.mono_on = mono;
		cur_sel = sel;
		cur_mono = mono;
		send_frame(f);
	endtask

	task automatic run_random(input int unsigned count, input int unsigned flip_odds);
		frame_t f;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, flip_odds - 1) == 0) cur_sel = ~cur_sel;
			if ($urandom_range(0, flip_odds - 1) == 0) cur_mono = ~cur_mono;
			f.main_left = pick_sample();
			f.main_right = pick_sample();
			f.ref_left = pick_sample();
			f.ref_right = pick_sample();
			f.select_b = cur_sel;
			f.mono_on = cur_mono;
			send_frame(f);
		end
	endtask

	task automatic drain();
		frame_valid <= 1'b0;
		while (sb.pending_mix.size() != 0) @(posedge clk);
	endtask

	task automatic program_steps(input logic [Q_W-1:0] fade, input logic [Q_W-1:0] mono);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= REG_FADE_STEP;
		cfg_data <= fade;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(REG_FADE_STEP, fade);
		cfg_index <= REG_MONO_STEP;
		cfg_data <= mono;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(REG_MONO_STEP, mono);
		cfg_valid <= 1'b0;
	endtask

	// result side: random stalls plus a long hold now and then
	initial begin
		int unsigned gap, calm, got_count;
		calm = 0;
		got_count = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (calm > 0) begin
				calm--;
				gap = 0;
			end else begin
				gap = $urandom_range(0, 4);
				if ($urandom_range(0, 24) == 0) calm = $urandom_range(10, 40);
			end
			if (got_count % 200 == 100) gap = 80;
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			sb.check_mix(result);
			got_count++;
		end
	end

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// settled on a, then a slow fade and mono ramp at the reset steps
		send_fields('0, '0, '0, '0, 1'b0, 1'b0);
		send_fields(SMAX, SMIN, SMIN, SMAX, 1'b0, 1'b0);
		send_fields(SMIN, SMAX, SMAX, SMIN, 1'b0, 1'b0);
		send_fields('1, 24'sd1, SMAX, SMAX, 1'b0, 1'b0);
		send_fields(SMAX, SMAX, SMAX, SMAX, 1'b1, 1'b0);
		send_fields(SMIN, SMIN, SMIN, SMIN, 1'b1, 1'b0);
		send_fields(SMAX, SMIN, SMAX, SMIN, 1'b1, 1'b1);
		send_fields(SMIN, SMAX, 24'sd12345, -24'sd54321, 1'b1, 1'b1);
		send_fields(SMAX, SMIN, SMIN, SMAX, 1'b0, 1'b1);
		send_fields(24'sd1, '1, '1, 24'sd1, 1'b0, 1'b0);
		send_fields(SMIN, SMAX, '0, '0, 1'b0, 1'b0);
		send_fields(SMAX, SMAX, SMIN, SMIN, 1'b0, 1'b0);
		run_random(100, 40);

		// oversized steps jump straight to the target
		program_steps('1, '1);
		run_random(60, 4);

		program_steps(24'd1, 24'd1);
		run_random(30, 10);

		program_steps(24'd300000, 24'd150000);
		run_random(150, 30);
		drain();
		run_random(150, 30);

		// full step, then park mid-ramp and freeze both ramps there
		program_steps(ONE_Q23, ONE_Q23);
		run_random(40, 6);
		send_fields(SMAX, SMIN, SMIN, SMAX, 1'b0, 1'b0);
		program_steps(24'd3000000, 24'd3000000);
		send_fields(SMAX, SMAX, SMAX, SMAX, 1'b1, 1'b1);
		program_steps('0, '0);
		run_random(40, 5);

		program_steps(STEP_RESET, STEP_RESET);
		run_random(60, 40);

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_mix.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
